@@ src/sgdm_pkg.sv @@
// ============================================================================
// sgdm_pkg
// Shared types, widths and helpers for the SGD momentum update unit.
// ============================================================================
package sgdm_pkg;

    localparam int VALUE_WIDTH     = 32;
    localparam int STORE_DEPTH     = 4096;
    localparam int INDEX_WIDTH     = $clog2(STORE_DEPTH);
    localparam int LR_WIDTH        = 24;
    localparam int MOM_WIDTH       = 17;
    localparam int FRAC_BITS       = 16;

    localparam int CFG_INDEX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH  = LR_WIDTH;

    localparam int S_FIELD_BITS    = INDEX_WIDTH + 2 * VALUE_WIDTH;
    localparam int S_TDATA_WIDTH   = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH   = 2 * VALUE_WIDTH;

    // momentum * velocity, momentum zero-extended to a signed operand
    localparam int MOM_PROD_WIDTH  = VALUE_WIDTH + MOM_WIDTH + 1;
    localparam int MOM_TERM_WIDTH  = MOM_PROD_WIDTH - FRAC_BITS;
    // step size * velocity
    localparam int LR_PROD_WIDTH   = VALUE_WIDTH + LR_WIDTH + 1;
    localparam int LR_TERM_WIDTH   = LR_PROD_WIDTH - FRAC_BITS;
    // wide enough for param - lr_term and for mom_term + grad
    localparam int CLAMP_WIDTH     = LR_TERM_WIDTH + 1;

    localparam int FIFO_DEPTH      = 8;
    localparam int FIFO_PTR_WIDTH  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_WIDTH  = FIFO_PTR_WIDTH + 1;

    localparam logic [LR_WIDTH-1:0]  LR_RESET  = LR_WIDTH'(655);
    localparam logic [MOM_WIDTH-1:0] MOM_RESET = MOM_WIDTH'(58982);

    localparam logic signed [CLAMP_WIDTH-1:0] VAL_MAX_WIDE =
        {{(CLAMP_WIDTH - VALUE_WIDTH + 1){1'b0}}, {(VALUE_WIDTH - 1){1'b1}}};
    localparam logic signed [CLAMP_WIDTH-1:0] VAL_MIN_WIDE =
        {{(CLAMP_WIDTH - VALUE_WIDTH + 1){1'b1}}, {(VALUE_WIDTH - 1){1'b0}}};

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_STEP_SIZE = 1'b0,
        REG_MOMENTUM  = 1'b1
    } cfg_reg_t;

    typedef logic signed [VALUE_WIDTH-1:0] value_t;

    typedef struct packed {
        value_t value;
        logic   sat;
    } clamp_t;

    typedef struct packed {
        value_t new_velocity;
        value_t new_param;
        logic   saturated;
    } out_item_t;

    // Saturate a wide signed value to VALUE_WIDTH bits.
    function automatic clamp_t clamp_value(input logic signed [CLAMP_WIDTH-1:0] x);
        clamp_t r;
        if (x > VAL_MAX_WIDE) begin
            r.value = VAL_MAX_WIDE[VALUE_WIDTH-1:0];
            r.sat   = 1'b1;
        end else if (x < VAL_MIN_WIDE) begin
            r.value = VAL_MIN_WIDE[VALUE_WIDTH-1:0];
            r.sat   = 1'b1;
        end else begin
            r.value = x[VALUE_WIDTH-1:0];
            r.sat   = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ src/sgdm_ram.sv @@
// ============================================================================
// sgdm_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ============================================================================
module sgdm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

@@ src/sgd_momentum_update_unit.sv @@
// ============================================================================
// sgd_momentum_update_unit
// SGD with momentum, one weight element per request, velocity kept in RAM.
// ============================================================================
// Path: a request goes through the velocity RMW, step-size multiply and
// subtract/clamp stages and the output queue before it shows on m_tvalid.
// Throughput: one request per cycle while s_tready is high, set by the
// single-stage velocity RMW (one RAM read port, one write port, one-deep forward).
// Reset: a clearing pass zeroes all 4096 velocity entries, one per cycle;
// s_tready stays low until the pass ends. Config writes are taken anyway.
// ============================================================================
module sgd_momentum_update_unit
    import sgdm_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_wr_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_wr_data,

    input  logic                       s_tvalid,
    output logic                       s_tready,
    // s_tdata: element_index[11:0], param_value[43:12], grad_value[75:44], zero pad
    input  logic [S_TDATA_WIDTH-1:0]   s_tdata,

    output logic                       m_tvalid,
    input  logic                       m_tready,
    // m_tdata: new_param[31:0], new_velocity[63:32]
    output logic [M_TDATA_WIDTH-1:0]   m_tdata,
    // m_tuser: saturated[0]
    output logic                       m_tuser
);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [LR_WIDTH-1:0]  lr_reg,  lr_next;
    logic [MOM_WIDTH-1:0] mom_reg, mom_next;
    logic                 mom_nz;

    always_comb begin
        lr_next  = lr_reg;
        mom_next = mom_reg;
        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_wr_index))
                REG_STEP_SIZE: lr_next  = cfg_wr_data[LR_WIDTH-1:0];
                REG_MOMENTUM:  mom_next = cfg_wr_data[MOM_WIDTH-1:0];
            endcase
        end
    end

    // zero momentum is plain SGD: requests do not write the store
    assign mom_nz = (mom_reg != '0);

    // ------------------------------------------------------------------
    // Clearing pass after reset
    // ------------------------------------------------------------------
    logic                   clear_reg,      clear_next;
    logic [INDEX_WIDTH-1:0] clear_addr_reg, clear_addr_next;

    always_comb begin
        clear_next      = clear_reg;
        clear_addr_next = clear_addr_reg;
        if (clear_reg) begin
            clear_addr_next = clear_addr_reg + 1'b1;
            if (clear_addr_reg == INDEX_WIDTH'(STORE_DEPTH - 1)) begin
                clear_next = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input unpack and acceptance
    // ------------------------------------------------------------------
    logic [INDEX_WIDTH-1:0] in_idx;
    value_t                 in_param;
    value_t                 in_grad;
    logic                   in_acc;
    logic                   out_acc;

    assign in_idx   = s_tdata[INDEX_WIDTH-1:0];
    assign in_param = s_tdata[INDEX_WIDTH +: VALUE_WIDTH];
    assign in_grad  = s_tdata[INDEX_WIDTH + VALUE_WIDTH +: VALUE_WIDTH];

    // Requests in flight (pipeline plus output queue) never exceed the queue
    // depth, so the pipeline itself never stalls.
    logic [FIFO_CNT_WIDTH-1:0] flight_reg, flight_next;

    assign s_tready = !clear_reg && (flight_reg != FIFO_CNT_WIDTH'(FIFO_DEPTH));
    assign in_acc   = s_tvalid && s_tready;

    always_comb begin
        flight_next = flight_reg;
        if (in_acc && !out_acc) begin
            flight_next = flight_reg + 1'b1;
        end else if (!in_acc && out_acc) begin
            flight_next = flight_reg - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Velocity store
    // ------------------------------------------------------------------
    logic                   ram_wr_en;
    logic [INDEX_WIDTH-1:0] ram_wr_addr;
    value_t                 ram_wr_data;
    value_t                 ram_rd_data;

    sgdm_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (STORE_DEPTH)
    ) u_vel_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (in_idx),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Stage 1: velocity read-modify-write
    // ------------------------------------------------------------------
    logic                   s1_valid_reg, s1_valid_next;
    logic [INDEX_WIDTH-1:0] s1_idx_reg;
    value_t                 s1_param_reg;
    value_t                 s1_grad_reg;

    logic                   s2_valid_reg, s2_valid_next;
    logic                   s2_wr_reg;
    logic [INDEX_WIDTH-1:0] s2_idx_reg;
    value_t                 s2_param_reg;
    value_t                 s2_vel_reg;
    logic                   s2_sat_reg;

    value_t                             vel_old;
    logic signed [MOM_PROD_WIDTH-1:0]   mom_prod;
    logic signed [MOM_TERM_WIDTH-1:0]   mom_term;
    logic signed [CLAMP_WIDTH-1:0]      vel_wide;
    clamp_t                             vel_clamp;
    value_t                             vel_new;
    logic                               vel_sat;
    logic                               s1_wr;

    assign s1_valid_next = in_acc;

    // The entry written by the request one ahead lands in RAM at the same
    // edge this request read it, so the RAM returns the stale value: forward.
    assign vel_old = (s2_valid_reg && s2_wr_reg && (s2_idx_reg == s1_idx_reg))
                     ? s2_vel_reg : ram_rd_data;

    // floor(v * m / 2^16): arithmetic shift by dropping the fraction bits
    assign mom_prod  = vel_old * $signed({1'b0, mom_reg});
    assign mom_term  = mom_prod[MOM_PROD_WIDTH-1:FRAC_BITS];
    assign vel_wide  = CLAMP_WIDTH'(mom_term) + CLAMP_WIDTH'(s1_grad_reg);
    assign vel_clamp = clamp_value(vel_wide);
    assign vel_new   = mom_nz ? vel_clamp.value : s1_grad_reg;
    assign vel_sat   = mom_nz && vel_clamp.sat;
    assign s1_wr     = s1_valid_reg && mom_nz;

    assign ram_wr_en   = clear_reg || s1_wr;
    assign ram_wr_addr = clear_reg ? clear_addr_reg : s1_idx_reg;
    assign ram_wr_data = clear_reg ? '0 : vel_new;

    assign s2_valid_next = s1_valid_reg;

    // ------------------------------------------------------------------
    // Stage 2: step-size multiply
    // ------------------------------------------------------------------
    logic signed [LR_PROD_WIDTH-1:0] lr_prod;

    logic                            s3_valid_reg, s3_valid_next;
    value_t                          s3_param_reg;
    value_t                          s3_vel_reg;
    logic                            s3_sat_reg;
    logic signed [LR_TERM_WIDTH-1:0] s3_lr_term_reg;

    assign lr_prod       = s2_vel_reg * $signed({1'b0, lr_reg});
    assign s3_valid_next = s2_valid_reg;

    // ------------------------------------------------------------------
    // Stage 3: subtract and saturate
    // ------------------------------------------------------------------
    logic signed [CLAMP_WIDTH-1:0] param_wide;
    clamp_t                        param_clamp;
    out_item_t                     push_item;

    assign param_wide  = CLAMP_WIDTH'(s3_param_reg) - CLAMP_WIDTH'(s3_lr_term_reg);
    assign param_clamp = clamp_value(param_wide);

    assign push_item.new_param    = param_clamp.value;
    assign push_item.new_velocity = s3_vel_reg;
    assign push_item.saturated    = s3_sat_reg || param_clamp.sat;

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    out_item_t                 fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_WIDTH-1:0] wr_ptr_reg,   wr_ptr_next;
    logic [FIFO_PTR_WIDTH-1:0] rd_ptr_reg,   rd_ptr_next;
    logic [FIFO_CNT_WIDTH-1:0] fifo_cnt_reg, fifo_cnt_next;
    out_item_t                 head_item;

    assign head_item = fifo_mem[rd_ptr_reg];
    assign m_tvalid  = (fifo_cnt_reg != '0);
    assign m_tdata   = {head_item.new_velocity, head_item.new_param};
    assign m_tuser   = head_item.saturated;
    assign out_acc   = m_tvalid && m_tready;

    always_comb begin
        wr_ptr_next   = s3_valid_reg ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next   = out_acc ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fifo_cnt_next = fifo_cnt_reg;
        if (s3_valid_reg && !out_acc) begin
            fifo_cnt_next = fifo_cnt_reg + 1'b1;
        end else if (!s3_valid_reg && out_acc) begin
            fifo_cnt_next = fifo_cnt_reg - 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lr_reg         <= LR_RESET;
            mom_reg        <= MOM_RESET;
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
            flight_reg     <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s3_valid_reg   <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_cnt_reg   <= '0;
        end else begin
            lr_reg         <= lr_next;
            mom_reg        <= mom_next;
            clear_reg      <= clear_next;
            clear_addr_reg <= clear_addr_next;
            flight_reg     <= flight_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            s3_valid_reg   <= s3_valid_next;
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            fifo_cnt_reg   <= fifo_cnt_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        s1_idx_reg     <= in_idx;
        s1_param_reg   <= in_param;
        s1_grad_reg    <= in_grad;

        s2_wr_reg      <= s1_wr;
        s2_idx_reg     <= s1_idx_reg;
        s2_param_reg   <= s1_param_reg;
        s2_vel_reg     <= vel_new;
        s2_sat_reg     <= vel_sat;

        s3_param_reg   <= s2_param_reg;
        s3_vel_reg     <= s2_vel_reg;
        s3_sat_reg     <= s2_sat_reg;
        s3_lr_term_reg <= lr_prod[LR_PROD_WIDTH-1:FRAC_BITS];

        if (s3_valid_reg) begin
            fifo_mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule
